/* hdl/shclp_pkg.sv */
// ----------------------------------------------------------------------------
// shclp_pkg
// Shared constants, codes and helpers of the serial hex color line parser.
// ----------------------------------------------------------------------------
package shclp_pkg;

    localparam int LINE_CAPACITY = 64;
    localparam int HEAD_DEPTH    = 8;
    localparam int HEAD_AW       = 3;

    localparam logic [7:0] DEL_BYTE   = 8'd127;
    localparam logic [7:0] CR_BYTE    = 8'd13;
    localparam logic [7:0] HASH_BYTE  = 8'd35;
    localparam logic [7:0] BS_BYTE    = 8'd8;
    localparam logic [7:0] SPACE_BYTE = 8'd32;

    localparam logic KIND_ECHO  = 1'b0;
    localparam logic KIND_COLOR = 1'b1;

    // pending work of one accepted byte
    typedef enum logic [2:0] {
        OP_ECHO  = 3'b001,
        OP_DEL   = 3'b010,
        OP_COLOR = 3'b100
    } t_op;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.valid = 1'b1;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.value = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.value = 4'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.value = 4'(c - 8'h57);
        end else begin
            h.valid = 1'b0;
        end
        return h;
    endfunction

endpackage

/* hdl/serial_hex_color_line_parser_top.sv */
// ----------------------------------------------------------------------------
// serial_hex_color_line_parser_top
// Line editor for received serial bytes with '#RRGGBB' color recognition.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry one received byte
// (i_rx_byte). Output channel: o_out_valid / i_out_stall carry one result
// (o_kind, o_echo_byte, o_red, o_green, o_blue, o_last); o_last marks the
// final result of a byte.
// A byte is decoded in the cycle it is taken: line state is updated and its
// results are placed in a pending register. The pending register feeds the
// output register one result per cycle while the receiver does not stall.
// Results pass both registers. Ordinary bytes, delete on an empty line
// and accepted lines give one result; delete on a non-empty line gives four
// (backspace, space, backspace, delete). A carriage return on a rejected
// line gives none.
// Throughput: one byte per cycle when each byte gives one result and no
// stall comes; deletes are held back by the single output register.
// Reset (synchronous, active low) empties the line and drops all results.
// While the receiver stalls, the output holds, the pending register fills
// and o_in_stall rises until the pending results can move on.
// ----------------------------------------------------------------------------
module serial_hex_color_line_parser_top #(
    parameter int LINE_CAPACITY = shclp_pkg::LINE_CAPACITY
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_kind,
    output logic [7:0] o_echo_byte,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue,
    output logic       o_last
);

    localparam int CW = $clog2(LINE_CAPACITY + 1);
    localparam logic [CW-1:0] LP_CAP   = CW'(LINE_CAPACITY);
    localparam logic [CW-1:0] LP_HEAD  = CW'(shclp_pkg::HEAD_DEPTH);
    localparam logic [CW-1:0] LP_SEVEN = CW'(7);

    // line state
    logic [CW-1:0] r_count, n_count;
    logic [7:0]    r_head [shclp_pkg::HEAD_DEPTH];

    // pending results
    logic           r_pend_valid, n_pend_valid;
    shclp_pkg::t_op r_pend_op, n_pend_op;
    logic [7:0]     r_pend_byte, n_pend_byte;
    logic [23:0]    r_pend_rgb, n_pend_rgb;
    logic [1:0]     r_pend_idx, n_pend_idx;

    // output register
    logic       r_out_valid;
    logic       r_out_kind;
    logic [7:0] r_out_echo;
    logic [23:0] r_out_rgb;
    logic       r_out_last;

    logic       in_accept;
    logic       out_load;
    logic       pend_done;
    logic       line_ok;
    logic [23:0] color;
    logic       e_kind;
    logic [7:0] e_echo;
    logic [23:0] e_rgb;
    logic       e_last;
    shclp_pkg::t_hex hx [6];

    // element of the pending transaction at the current index
    always_comb begin
        e_kind = shclp_pkg::KIND_ECHO;
        e_echo = 8'd0;
        e_rgb  = 24'd0;
        e_last = 1'b1;
        unique case (r_pend_op)
            shclp_pkg::OP_ECHO: begin
                e_echo = r_pend_byte;
            end
            shclp_pkg::OP_DEL: begin
                e_last = (r_pend_idx == 2'd3);
                case (r_pend_idx)
                    2'd0, 2'd2: e_echo = shclp_pkg::BS_BYTE;
                    2'd1:       e_echo = shclp_pkg::SPACE_BYTE;
                    default:    e_echo = shclp_pkg::DEL_BYTE;
                endcase
            end
            shclp_pkg::OP_COLOR: begin
                e_kind = shclp_pkg::KIND_COLOR;
                e_rgb  = r_pend_rgb;
            end
            default: begin
                e_echo = r_pend_byte;
            end
        endcase
    end

    assign out_load   = r_pend_valid && (!r_out_valid || !i_out_stall);
    assign pend_done  = out_load && e_last;
    assign o_in_stall = r_pend_valid && !pend_done;
    assign in_accept  = i_in_valid && !o_in_stall;

    // acceptance check of the held line
    always_comb begin
        for (int i = 0; i < 6; i++) begin
            hx[3'(i)] = shclp_pkg::hex_decode(r_head[3'(i + 1)]);
        end
        color = {hx[0].value, hx[1].value, hx[2].value,
                 hx[3].value, hx[4].value, hx[5].value};
        line_ok = (r_count >= LP_SEVEN)
            && ((r_count == LP_SEVEN) || (r_head[7] == 8'd0))
            && (r_head[0] == shclp_pkg::HASH_BYTE)
            && hx[0].valid && hx[1].valid && hx[2].valid
            && hx[3].valid && hx[4].valid && hx[5].valid;
    end

    always_comb begin
        n_count      = r_count;
        n_pend_valid = r_pend_valid;
        n_pend_op    = r_pend_op;
        n_pend_byte  = r_pend_byte;
        n_pend_rgb   = r_pend_rgb;
        n_pend_idx   = r_pend_idx;
        if (out_load) begin
            n_pend_idx = r_pend_idx + 2'd1;
            if (e_last) begin
                n_pend_valid = 1'b0;
            end
        end
        if (in_accept) begin
            n_pend_idx  = 2'd0;
            n_pend_byte = i_rx_byte;
            n_pend_rgb  = color;
            if (i_rx_byte == shclp_pkg::CR_BYTE) begin
                n_count      = '0;
                n_pend_valid = line_ok;
                n_pend_op    = shclp_pkg::OP_COLOR;
            end else if (i_rx_byte == shclp_pkg::DEL_BYTE) begin
                n_pend_valid = 1'b1;
                if (r_count != '0) begin
                    n_count   = r_count - CW'(1);
                    n_pend_op = shclp_pkg::OP_DEL;
                end else begin
                    n_pend_op = shclp_pkg::OP_ECHO;
                end
            end else begin
                n_pend_valid = 1'b1;
                n_pend_op    = shclp_pkg::OP_ECHO;
                if (r_count < LP_CAP) begin
                    n_count = r_count + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_pend_op    <= shclp_pkg::OP_ECHO;
            r_pend_idx   <= 2'd0;
            r_out_valid  <= 1'b0;
        end else begin
            r_count      <= n_count;
            r_pend_valid <= n_pend_valid;
            r_pend_op    <= n_pend_op;
            r_pend_idx   <= n_pend_idx;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_byte <= n_pend_byte;
        r_pend_rgb  <= n_pend_rgb;
        if (out_load) begin
            r_out_kind <= e_kind;
            r_out_echo <= e_echo;
            r_out_rgb  <= e_rgb;
            r_out_last <= e_last;
        end
        if (in_accept && (i_rx_byte != shclp_pkg::CR_BYTE)
                && (i_rx_byte != shclp_pkg::DEL_BYTE)
                && (r_count < LP_CAP) && (r_count < LP_HEAD)) begin
            r_head[r_count[shclp_pkg::HEAD_AW-1:0]] <= i_rx_byte;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_out_kind;
    assign o_echo_byte = r_out_echo;
    assign o_red       = r_out_rgb[23:16];
    assign o_green     = r_out_rgb[15:8];
    assign o_blue      = r_out_rgb[7:0];
    assign o_last      = r_out_last;

endmodule
